@@ rtl/pafe_pkg.sv @@
// Shared types, codeword constants and BCH(31,21) helpers for the POCSAG frame encoder.
package pafe_pkg;

  localparam logic [31:0] SYNC_WORD     = 32'h7CD215D8;
  localparam logic [31:0] IDLE_WORD     = 32'h7A89C197;
  localparam logic [31:0] PREAMBLE_WORD = 32'hAAAAAAAA;
  localparam logic [31:0] BCH_POLY      = 32'hED200000;
  localparam logic [6:0]  EOT_CHAR      = 7'h04;
  localparam int unsigned MSG_BITS      = 20;
  localparam int unsigned DATA_BITS     = 21;
  localparam int unsigned CHECK_BITS    = 10;

  typedef struct packed {
    logic [6:0] char_rev;
    logic       has_char;
    logic       last;
  } pafe_cmd_t;

  function automatic logic [6:0] rev7(input logic [6:0] c);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) begin
      r[i] = c[6-i];
    end
    return r;
  endfunction

  function automatic logic [CHECK_BITS-1:0] bch_row(input int unsigned j);
    logic [31:0] r;
    r = 32'h1 << j;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (r[31]) begin
        r = r ^ BCH_POLY;
      end
      r = r << 1;
    end
    return r[31:22];
  endfunction

  function automatic logic [DATA_BITS-1:0][CHECK_BITS-1:0] bch_table();
    logic [DATA_BITS-1:0][CHECK_BITS-1:0] t;
    for (int k = 0; k < DATA_BITS; k++) begin
      t[k] = bch_row(k + 11);
    end
    return t;
  endfunction

  localparam logic [DATA_BITS-1:0][CHECK_BITS-1:0] BCH_TABLE = bch_table();

  // d is codeword bits 31..11
  function automatic logic [31:0] add_check(input logic [DATA_BITS-1:0] d);
    logic [CHECK_BITS-1:0] chk;
    logic [31:0]           w;
    chk = '0;
    for (int k = 0; k < DATA_BITS; k++) begin
      if (d[k]) begin
        chk = chk ^ BCH_TABLE[k];
      end
    end
    w    = {d, chk, 1'b0};
    w[0] = ^w;
    return w;
  endfunction

endpackage

@@ rtl/pafe_front.sv @@
// Input side: accepts characters, bit-reverses them and queues commands for the back end.
module pafe_front
  import pafe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [6:0] in_character,
  input  logic       in_has_char,
  input  logic       in_last,
  output logic       cmd_empty,
  input  logic       cmd_pop,
  output pafe_cmd_t  cmd
);

  pafe_cmd_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign in_full   = (count_r == 2'd2);
  assign cmd_empty = (count_r == 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && !cmd_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= '{char_rev: rev7(in_character), has_char: in_has_char, last: in_last};
    end
  end

endmodule

@@ rtl/pafe_back.sv @@
// Codeword sequencer: framing, bit packing, batch fill and the output register.
module pafe_back
  import pafe_pkg::*;
#(
  parameter int PREAMBLE_BITS = 576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pafe_cmd_t   cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  input  logic [20:0] pager_address,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_codeword,
  output logic        out_end_of_transmission
);

  localparam int PRE_WORDS = PREAMBLE_BITS / 32;
  localparam int PRE_W     = $clog2(PRE_WORDS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PRE   = 8'b0000_0010,
    S_FRAME = 8'b0000_0100,
    S_CHAR  = 8'b0000_1000,
    S_MSG   = 8'b0001_0000,
    S_EOT   = 8'b0010_0000,
    S_PAD   = 8'b0100_0000,
    S_FILL  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [PRE_W-1:0] pre_cnt_r, pre_cnt_nxt;
  logic [25:0]      store_r, store_nxt;
  logic [4:0]       held_r, held_nxt;
  logic [3:0]       slot_r, slot_nxt;
  logic             sync_sent_r, sync_sent_nxt;
  logic             started_r, started_nxt;
  logic             closing_r, closing_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_word_r;
  logic             out_eot_r;

  logic             emit_ok, emit, eot;
  logic [31:0]      word;
  logic             sync_due;
  logic [3:0]       slot_inc;
  logic [4:0]       held_after;
  logic [4:0]       held_add;
  logic [19:0]      msg_bits, pad_bits;
  logic [25:0]      store_app_char, store_app_eot;

  assign emit_ok        = !out_valid_r || out_pop;
  assign sync_due       = (slot_r == 4'd0) && !sync_sent_r;
  assign slot_inc       = slot_r + 4'd1;
  assign held_after     = held_r - 5'd20;
  assign held_add       = held_r + 5'd7;
  assign msg_bits       = 20'(store_r >> held_after);
  assign pad_bits       = store_r[19:0] << (5'd20 - held_r);
  assign store_app_char = {store_r[18:0], cmd.char_rev};
  assign store_app_eot  = {store_r[18:0], rev7(EOT_CHAR)};

  always_comb begin
    state_nxt     = state_r;
    pre_cnt_nxt   = pre_cnt_r;
    store_nxt     = store_r;
    held_nxt      = held_r;
    slot_nxt      = slot_r;
    sync_sent_nxt = sync_sent_r;
    started_nxt   = started_r;
    closing_nxt   = closing_r;
    emit          = 1'b0;
    eot           = 1'b0;
    word          = '0;
    cmd_pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          if (started_r) begin
            state_nxt = S_CHAR;
          end else begin
            state_nxt   = S_PRE;
            pre_cnt_nxt = '0;
          end
        end
      end
      S_PRE: begin
        if (emit_ok) begin
          emit = 1'b1;
          word = PREAMBLE_WORD;
          if (pre_cnt_r == PRE_W'(PRE_WORDS - 1)) begin
            state_nxt     = S_FRAME;
            slot_nxt      = '0;
            store_nxt     = '0;
            held_nxt      = '0;
            sync_sent_nxt = 1'b0;
          end else begin
            pre_cnt_nxt = pre_cnt_r + PRE_W'(1);
          end
        end
      end
      S_FRAME: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (sync_due) begin
            word          = SYNC_WORD;
            sync_sent_nxt = 1'b1;
          end else begin
            slot_nxt      = slot_inc;
            sync_sent_nxt = 1'b0;
            if (slot_r == {pager_address[2:0], 1'b0}) begin
              word        = add_check({1'b0, pager_address[20:3], 2'b11});
              started_nxt = 1'b1;
              state_nxt   = S_CHAR;
            end else begin
              word = IDLE_WORD;
            end
          end
        end
      end
      S_CHAR: begin
        closing_nxt = 1'b0;
        if (cmd.has_char) begin
          store_nxt = store_app_char;
          held_nxt  = held_add;
          state_nxt = (held_add >= 5'd20) ? S_MSG : S_EOT;
        end else begin
          state_nxt = S_EOT;
        end
      end
      S_MSG: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (sync_due) begin
            word          = SYNC_WORD;
            sync_sent_nxt = 1'b1;
          end else begin
            word          = add_check({1'b1, msg_bits});
            held_nxt      = held_after;
            store_nxt     = store_r & ((26'd1 << held_after) - 26'd1);
            slot_nxt      = slot_inc;
            sync_sent_nxt = 1'b0;
            if (closing_r) begin
              eot       = (slot_inc == 4'd0) && (held_after == 5'd0);
              state_nxt = S_PAD;
            end else begin
              state_nxt = S_EOT;
            end
          end
        end
      end
      S_EOT: begin
        if (cmd.last) begin
          store_nxt   = store_app_eot;
          held_nxt    = held_add;
          closing_nxt = 1'b1;
          state_nxt   = (held_add >= 5'd20) ? S_MSG : S_PAD;
        end else begin
          cmd_pop   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        if (held_r == 5'd0) begin
          state_nxt = S_FILL;
        end else if (emit_ok) begin
          emit = 1'b1;
          if (sync_due) begin
            word          = SYNC_WORD;
            sync_sent_nxt = 1'b1;
          end else begin
            word          = add_check({1'b1, pad_bits});
            held_nxt      = '0;
            store_nxt     = '0;
            slot_nxt      = slot_inc;
            sync_sent_nxt = 1'b0;
            eot           = (slot_inc == 4'd0);
            state_nxt     = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (slot_r == 4'd0) begin
          cmd_pop       = 1'b1;
          started_nxt   = 1'b0;
          store_nxt     = '0;
          held_nxt      = '0;
          sync_sent_nxt = 1'b0;
          closing_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else if (emit_ok) begin
          emit     = 1'b1;
          word     = IDLE_WORD;
          slot_nxt = slot_inc;
          eot      = (slot_inc == 4'd0);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pre_cnt_r   <= '0;
      store_r     <= '0;
      held_r      <= '0;
      slot_r      <= '0;
      sync_sent_r <= 1'b0;
      started_r   <= 1'b0;
      closing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      store_r     <= store_nxt;
      held_r      <= held_nxt;
      slot_r      <= slot_nxt;
      sync_sent_r <= sync_sent_nxt;
      started_r   <= started_nxt;
      closing_r   <= closing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= word;
      out_eot_r  <= eot;
    end
  end

  assign out_empty               = !out_valid_r;
  assign out_codeword            = out_word_r;
  assign out_end_of_transmission = out_eot_r;

endmodule

@@ rtl/pocsag_alpha_frame_encoder.sv @@
// Top level of the POCSAG alphanumeric frame encoder with address register.
// Throughput: up to one codeword per cycle while out_pop drains the output register; a character
// with no framing steps the sequencer through a queue check, an append, an optional sync and
// message word, and a pop. The first item adds PREAMBLE_BITS/32 preamble words and the frame
// words up to the address slot; the last adds batch fill.
// Synchronous active-low reset clears queue, sequencer, output register and address.
module pocsag_alpha_frame_encoder
  import pafe_pkg::*;
#(
  parameter int PREAMBLE_BITS = 576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [6:0]  in_character,
  input  logic        in_has_char,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_codeword,
  output logic        out_end_of_transmission,
  input  logic        cfg_write_en,
  input  logic [20:0] cfg_pager_address
);

  logic [20:0] pager_address_r;
  pafe_cmd_t   cmd;
  logic        cmd_empty;
  logic        cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pager_address_r <= '0;
    end else if (cfg_write_en) begin
      pager_address_r <= cfg_pager_address;
    end
  end

  pafe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_character (in_character),
    .in_has_char  (in_has_char),
    .in_last      (in_last),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd)
  );

  pafe_back #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .cmd_empty               (cmd_empty),
    .cmd_pop                 (cmd_pop),
    .pager_address           (pager_address_r),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_codeword            (out_codeword),
    .out_end_of_transmission (out_end_of_transmission)
  );

endmodule

@@ rtl/pafe_checker.sv @@
// Port-level checker for the POCSAG frame encoder, bound to the top level.
module pafe_checker
  import pafe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_codeword,
  input logic        out_end_of_transmission
);

  logic after_eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_eot_r <= 1'b0;
    end else if (out_pop && !out_empty) begin
      after_eot_r <= out_end_of_transmission;
    end
  end

  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_codeword)))
    else $error("result beat changed before pop");

  a_even_parity: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (^out_codeword == 1'b0))
    else $error("codeword parity is odd");

  a_eot_not_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_end_of_transmission) |->
      (out_codeword != SYNC_WORD && out_codeword != PREAMBLE_WORD))
    else $error("end of transmission on a framing word");

  a_restart_preamble: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && after_eot_r) |-> (out_codeword == PREAMBLE_WORD))
    else $error("new transmission does not open with preamble");

endmodule

bind pocsag_alpha_frame_encoder pafe_checker u_pafe_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_empty               (out_empty),
  .out_pop                 (out_pop),
  .out_codeword            (out_codeword),
  .out_end_of_transmission (out_end_of_transmission)
);
